>>> rtl/int_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text converter.
// Every check is clocked on clk and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define IDA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define IDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ida_pkg.sv
// ----------------------------------------------------------------------------
// ida_pkg
// Shared widths, codes and the stage record of the decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ida_pkg;

	// Field widths of the two channels.
	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 4;

	// A 32-bit magnitude needs at most ten decimal digits.
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = DIGIT_W * NUM_DIGITS;

	// Command codes.
	localparam logic CMD_SIGNED   = 1'b0;
	localparam logic CMD_UNSIGNED = 1'b1;

	// Character codes.
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

	// Record carried through the conversion stages: sign, digits built so far
	// and the binary bits still to be shifted in.
	typedef struct packed {
		logic               neg;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} dab_t;

endpackage

`default_nettype wire

>>> rtl/ida_in_if.sv
// ----------------------------------------------------------------------------
// ida_in_if
// Request channel carrying one word and its signed or unsigned command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ida_in_if import ida_pkg::*; ();

	logic               valid;
	logic               ready;
	logic               cmd;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);

endinterface

`default_nettype wire

>>> rtl/ida_out_if.sv
// ----------------------------------------------------------------------------
// ida_out_if
// Request channel carrying one character of decimal text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ida_out_if import ida_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;
	logic [LEN_W-1:0]  length;

	modport source (output valid, output character, output last, output length, input ready);
	modport sink (input valid, input character, input last, input length, output ready);

endinterface

`default_nettype wire

>>> rtl/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a 32-bit word to signed or unsigned decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   number: one request per word; cmd selects signed (0) or unsigned (1)
//   decimal, value carries the word (trimmed to WORD_BITS bits).
//   text: one request per character, most significant digit first, with a
//   leading '-' for negative signed values; length is the character count
//   of the whole number and last marks its final character.
//   The first character is offered once the word has passed the sign stage,
//   four conversion stages, the count stage and the output register. The
//   single output register sets the rate: one character per cycle while the
//   receiver is ready; a number of N characters (1 to 11) holds it until its
//   last character goes, with no gap between numbers. Up to seven words are
//   in flight, so words are taken in every cycle until the pipe fills.
//   Reset empties every stage; no text is offered until a word arrives.
//   When the receiver stalls, the current character holds and the stages
//   behind it fill and then stop taking words; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_ascii import ida_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ida_in_if.sink    number,
	ida_out_if.source text
);

	logic s1_valid, s1_ready;
	dab_t s1_data;
	logic s5_valid, s5_ready;
	dab_t s5_data;

	// Sign and magnitude.
	ida_sign #(
		.WORD_BITS(WORD_BITS)
	) u_sign (
		.clk      (clk),
		.arst_n   (arst_n),
		.number   (number),
		.dn_valid (s1_valid),
		.dn_ready (s1_ready),
		.dn_data  (s1_data)
	);

	// Binary to BCD.
	ida_dabble u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s1_valid),
		.up_ready (s1_ready),
		.up_data  (s1_data),
		.dn_valid (s5_valid),
		.dn_ready (s5_ready),
		.dn_data  (s5_data)
	);

	// Digit count and character output.
	ida_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s5_valid),
		.up_ready (s5_ready),
		.up_data  (s5_data),
		.text     (text)
	);

endmodule

`default_nettype wire

>>> rtl/ida_sign.sv
// ----------------------------------------------------------------------------
// ida_sign
// First stage: trims the word to WORD_BITS and splits it into sign and
// magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ida_sign import ida_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ida_in_if.sink    number,
	output logic      dn_valid,
	input  wire logic dn_ready,
	output dab_t      dn_data
);

	// Bits of the word that can reach the 32-bit value field.
	localparam int VB = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;
	// A word wider than the field never has its sign bit set.
	localparam bit HAS_SIGN = (WORD_BITS <= VALUE_W);
	localparam logic [VALUE_W-1:0] MASK = {VALUE_W{1'b1}} >> (VALUE_W - VB);

	logic               v_s1;
	dab_t               d_s1;
	logic [VALUE_W-1:0] word;
	logic               neg;
	logic [VALUE_W-1:0] mag;

	// Sign and magnitude; the most negative value maps onto itself.
	always_comb begin
		word = number.value & MASK;
		neg  = HAS_SIGN && (number.cmd == CMD_SIGNED) && word[VB-1];
		mag  = neg ? ((~word + VALUE_W'(1)) & MASK) : word;
	end

	assign number.ready = !v_s1 || dn_ready;

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (number.ready) begin
			v_s1 <= number.valid;
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (number.valid && number.ready) begin
			d_s1.neg <= neg;
			d_s1.bcd <= '0;
			d_s1.bin <= mag;
		end
	end

	assign dn_valid = v_s1;
	assign dn_data  = d_s1;

endmodule

`default_nettype wire

>>> rtl/ida_dabble.sv
// ----------------------------------------------------------------------------
// ida_dabble
// Shift-and-add-three binary to BCD conversion, eight bit steps in each of
// four pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ida_dabble import ida_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic up_valid,
	output logic      up_ready,
	input  dab_t      up_data,
	output logic      dn_valid,
	input  wire logic dn_ready,
	output dab_t      dn_data
);

	localparam int STEPS_PER_STAGE = 8;

	// One step: correct every digit of five or more, then shift one bit in.
	function automatic dab_t dab_step(input dab_t d);
		dab_t       r;
		logic [3:0] dg;
		r = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			dg = r.bcd[DIGIT_W*i +: DIGIT_W];
			if (dg >= 4'd5) begin
				r.bcd[DIGIT_W*i +: DIGIT_W] = dg + 4'd3;
			end
		end
		{r.bcd, r.bin} = {r.bcd, r.bin} << 1;
		return r;
	endfunction

	function automatic dab_t dab_stage(input dab_t d);
		dab_t r;
		r = d;
		for (int k = 0; k < STEPS_PER_STAGE; k++) begin
			r = dab_step(r);
		end
		return r;
	endfunction

	logic v_s2, v_s3, v_s4, v_s5;
	dab_t d_s2, d_s3, d_s4, d_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// Each stage takes new data when it is empty or its successor takes.
	assign rdy_s5   = !v_s5 || dn_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign up_ready = rdy_s2;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= up_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Stage data, eight conversion steps between each pair of registers.
	always_ff @(posedge clk) begin
		if (up_valid && rdy_s2) d_s2 <= dab_stage(up_data);
		if (v_s2 && rdy_s3)     d_s3 <= dab_stage(d_s2);
		if (v_s3 && rdy_s4)     d_s4 <= dab_stage(d_s3);
		if (v_s4 && rdy_s5)     d_s5 <= dab_stage(d_s4);
	end

	assign dn_valid = v_s5;
	assign dn_data  = d_s5;

endmodule

`default_nettype wire

>>> rtl/ida_emit.sv
// ----------------------------------------------------------------------------
// ida_emit
// Counts the significant digits, aligns the most significant one to the top
// and sends the text out one character per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "int_to_decimal_ascii_assert.svh"

module ida_emit import ida_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic up_valid,
	output logic      up_ready,
	input  dab_t      up_data,
	ida_out_if.source text
);

	logic             v_s6;
	logic             neg_s6;
	logic [BCD_W-1:0] bcd_s6;
	logic [LEN_W-1:0] len_s6;

	logic             busy_q;
	logic             sgn_q;
	logic [BCD_W-1:0] bcd_q;
	logic [LEN_W-1:0] left_q;
	logic [LEN_W-1:0] len_q;

	logic [LEN_W-1:0] ndig;
	logic [LEN_W-1:0] shift;
	logic [BCD_W-1:0] aligned;
	logic             load;

	// Digit count (at least one, so zero gives "0") and left alignment.
	always_comb begin
		ndig = LEN_W'(1);
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (up_data.bcd[DIGIT_W*i +: DIGIT_W] != 4'd0) begin
				ndig = LEN_W'(i + 1);
			end
		end
		shift   = LEN_W'(NUM_DIGITS) - ndig;
		aligned = up_data.bcd << {shift, 2'b00};
	end

	// The output register reloads when empty or when its last character goes.
	assign load     = !busy_q || (text.ready && left_q == LEN_W'(1));
	assign up_ready = !v_s6 || load;

	// Count stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (up_ready) begin
			v_s6 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			neg_s6 <= up_data.neg;
			bcd_s6 <= aligned;
			len_s6 <= ndig + {{(LEN_W-1){1'b0}}, up_data.neg};
		end
	end

	// Character sequencer: the minus sign first, then digits from the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sgn_q  <= 1'b0;
			left_q <= '0;
		end else if (load) begin
			busy_q <= v_s6;
			sgn_q  <= neg_s6;
			left_q <= len_s6;
		end else if (text.ready) begin
			sgn_q  <= 1'b0;
			left_q <= left_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && v_s6) begin
			bcd_q <= bcd_s6;
			len_q <= len_s6;
		end else if (busy_q && text.ready && !sgn_q) begin
			bcd_q <= bcd_q << DIGIT_W;
		end
	end

	// Output channel.
	assign text.valid     = busy_q;
	assign text.character = sgn_q ? ASCII_MINUS
		: (ASCII_ZERO + {4'd0, bcd_q[BCD_W-1 -: DIGIT_W]});
	assign text.last      = (left_q == LEN_W'(1));
	assign text.length    = len_q;

	// The remaining count stays within the length of the number.
	`IDA_ASSERT(a_left_range, !busy_q || (left_q != 4'd0 && left_q <= len_q), "count out of range")
	// A minus sign is only ever the first character.
	`IDA_ASSERT(a_sign_first, !(busy_q && sgn_q) || left_q == len_q, "minus not first")
	// Every digit that leaves is a decimal digit.
	`IDA_ASSERT(a_digit_ok, !(busy_q && !sgn_q) || bcd_q[BCD_W-1 -: DIGIT_W] <= 4'd9, "bad digit")
	// A character that is not the last is followed by the next of the same number.
	`IDA_ASSERT_NEXT(a_advance, text.valid && text.ready && !text.last, busy_q && left_q == $past(left_q) - 4'd1, "lost char")

endmodule

`default_nettype wire

>>> dv/int_to_decimal_ascii_checker.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_checker
// Watches both request channels of the decimal text converter, works out the
// characters each accepted word must produce and compares every accepted
// character against them in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module int_to_decimal_ascii_checker import ida_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ida_in_if           number,
	ida_out_if          text,
	output int unsigned failures,
	output int unsigned pending
);

	// One character of decimal text as it should leave the block.
	typedef struct {
		logic [CHAR_W-1:0] character;
		logic              last;
		logic [LEN_W-1:0]  length;
	} text_char_t;

	text_char_t text_due[$];

	// Appends the decimal text of one word, sign first, then the digits from
	// the most significant one down. The most negative signed word wraps to
	// itself on negation, which as an unsigned magnitude is exactly 2^31.
	function automatic void predict_text(input logic cmd, input logic [VALUE_W-1:0] value);
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digits[NUM_DIGITS];
		int                 ndig;
		int                 total;
		text_char_t         c;
		neg  = (cmd == CMD_SIGNED) && value[VALUE_W-1];
		mag  = neg ? (~value + 1'b1) : value;
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 32'd10);
			ndig++;
			mag = mag / 32'd10;
		end while (mag != 0);
		total = ndig + (neg ? 1 : 0);
		if (neg) begin
			c.character = ASCII_MINUS;
			c.last      = (total == 1);
			c.length    = LEN_W'(total);
			text_due.push_back(c);
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			c.character = ASCII_ZERO + CHAR_W'(digits[k]);
			c.last      = (k == 0);
			c.length    = LEN_W'(total);
			text_due.push_back(c);
		end
	endfunction

	// Characters are checked before new words are predicted; a word never
	// produces text at the edge where it is taken. Mismatches of one edge are
	// summed first so that the failure count moves once per edge.
	always @(posedge clk) begin
		text_char_t  want;
		int unsigned errs;
		errs = 0;
		if (!arst_n) begin
			text_due.delete();
			failures <= 0;
			pending  <= 0;
		end else begin
			if (text.valid && text.ready) begin
				if (text_due.size() == 0) begin
					errs++;
					$display("%0t: character %0d (last %0b, length %0d) with none expected",
						$time, text.character, text.last, text.length);
				end else begin
					want = text_due.pop_front();
					if (text.character !== want.character) begin
						errs++;
						$display("%0t: character expected %0d, got %0d",
							$time, want.character, text.character);
					end
					if (text.last !== want.last) begin
						errs++;
						$display("%0t: last expected %0b, got %0b",
							$time, want.last, text.last);
					end
					if (text.length !== want.length) begin
						errs++;
						$display("%0t: length expected %0d, got %0d",
							$time, want.length, text.length);
					end
				end
			end
			if (number.valid && number.ready)
				predict_text(number.cmd, number.value);
			failures <= failures + errs;
			pending  <= text_due.size();
		end
	end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives words into the decimal text converter and pulls its characters,
// with the sender idling and the receiver stalling in several patterns, one
// long receiver hold-off and drained pauses between phases. The checker
// beside the block does the comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import ida_pkg::*;

	typedef enum {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} pace_t;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	pace_t       phase;
	int unsigned failures;
	int unsigned pending;
	int unsigned quiet_cycles = 0;

	ida_in_if  number_bus ();
	ida_out_if text_bus ();

	int_to_decimal_ascii u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_bus),
		.text   (text_bus)
	);

	int_to_decimal_ascii_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.number   (number_bus),
		.text     (text_bus),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offers one word, idling first as the phase asks, and returns once the
	// request has been taken.
	task automatic send_number(input logic cmd, input logic [VALUE_W-1:0] value);
		int unsigned idle_pct;
		idle_pct = (phase == PH_SEND_IDLE) ? 87 : (phase == PH_BOTH) ? 13 : 0;
		while ($urandom_range(99) < idle_pct) begin
			number_bus.valid <= 1'b0;
			@(posedge clk);
		end
		number_bus.valid <= 1'b1;
		number_bus.cmd   <= cmd;
		number_bus.value <= value;
		@(posedge clk);
		while (!number_bus.ready)
			@(posedge clk);
	endtask

	// Stops offering, switches the pacing and waits until every character
	// owed so far has arrived.
	task automatic change_phase(input pace_t next);
		number_bus.valid <= 1'b0;
		phase <= next;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// A mix of full-range words, short words, values around powers of ten
	// and small negatives.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		int unsigned        bits;
		case ($urandom_range(3))
			0: begin
				v = $urandom;
			end
			1: begin
				bits = $urandom_range(32, 1);
				v = $urandom >> (32 - bits);
			end
			2: begin
				v = 32'd1;
				repeat ($urandom_range(9))
					v = v * 32'd10;
				v = v + $urandom_range(2) - 1;
				if ($urandom_range(1))
					v = ~v + 1'b1;
			end
			default: begin
				v = ~VALUE_W'($urandom_range(1000)) + 1'b1;
			end
		endcase
		return v;
	endfunction

	// Receiver: stalls as the phase asks, and holds off once for a long
	// stretch, starting when everything owed has arrived, so that the sender
	// fills the block and it stops taking words.
	initial begin : receiver
		bit          hold_served;
		int unsigned stall_pct;
		hold_served   = 1'b0;
		text_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (phase == PH_HOLD && !hold_served && pending == 0) begin
				hold_served = 1'b1;
				text_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else begin
				stall_pct = (phase == PH_RECV_STALL) ? 87 : (phase == PH_BOTH) ? 13 : 0;
				text_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no request moves for too long.
	always @(posedge clk) begin
		if ((number_bus.valid && number_bus.ready) || (text_bus.valid && text_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("int_to_decimal_ascii regression: fail");
			$finish;
		end
	end

	initial begin
		pace_t       plan[6];
		int unsigned plan_items[6];
		plan       = '{PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD, PH_FREE};
		plan_items = '{50, 50, 50, 50, 40, 20};
		arst_n           = 1'b0;
		phase            = PH_FREE;
		number_bus.valid = 1'b0;
		number_bus.cmd   = CMD_SIGNED;
		number_bus.value = '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: zero, single digits, digit-count boundaries, both
		// extremes of each mode and the most negative signed word.
		send_number(CMD_SIGNED,   32'h0000_0000);
		send_number(CMD_UNSIGNED, 32'h0000_0000);
		send_number(CMD_SIGNED,   32'd1);
		send_number(CMD_UNSIGNED, 32'd9);
		send_number(CMD_SIGNED,   32'd10);
		send_number(CMD_UNSIGNED, 32'd99);
		send_number(CMD_SIGNED,   32'd100);
		send_number(CMD_SIGNED,   32'hFFFF_FFFF);
		send_number(CMD_UNSIGNED, 32'hFFFF_FFFF);
		send_number(CMD_SIGNED,   32'h8000_0000);
		send_number(CMD_UNSIGNED, 32'h8000_0000);
		send_number(CMD_SIGNED,   32'h7FFF_FFFF);
		send_number(CMD_UNSIGNED, 32'h7FFF_FFFF);
		send_number(CMD_SIGNED,   32'h8000_0001);
		send_number(CMD_SIGNED,   32'hFFFF_FFF7);
		send_number(CMD_SIGNED,   32'hFFFF_FFF6);
		send_number(CMD_SIGNED,   32'd999_999_999);
		send_number(CMD_SIGNED,   32'd1_000_000_000);
		send_number(CMD_UNSIGNED, 32'd3_999_999_999);
		send_number(CMD_UNSIGNED, 32'd4_000_000_000);
		send_number(CMD_SIGNED,   32'hC465_3600);
		send_number(CMD_UNSIGNED, 32'hAAAA_AAAA);
		send_number(CMD_SIGNED,   32'h5555_5555);

		// Random words under each pacing, draining between phases.
		for (int p = 0; p < 6; p++) begin
			change_phase(plan[p]);
			repeat (plan_items[p])
				send_number(logic'($urandom_range(1)), pick_value());
		end

		change_phase(PH_FREE);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (failures == 0 && pending == 0)
			$display("int_to_decimal_ascii regression: pass");
		else
			$display("int_to_decimal_ascii regression: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/ida_pkg.sv
rtl/ida_in_if.sv
rtl/ida_out_if.sv
rtl/ida_sign.sv
rtl/ida_dabble.sv
rtl/ida_emit.sv
rtl/int_to_decimal_ascii.sv
dv/int_to_decimal_ascii_checker.sv
dv/testbench.sv
